/* sv/rpb_pkg.sv */
// Shared types, constants and grid lookup functions for the rune Playfair block.
package rpb_pkg;

  localparam int SYM_W   = 5;
  localparam int GRID_N  = 5;
  localparam int IDX_W   = 3;
  localparam int ROW_W   = SYM_W * GRID_N;
  localparam int CFG_IDX_W = 3;

  localparam logic [SYM_W-1:0] SPACE_SYMBOL = 5'd29;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILLER   = 3'd5;

  // Reset values of the key grid and filler
  localparam logic [ROW_W-1:0] RESET_ROW0 = 25'd19239796;
  localparam logic [ROW_W-1:0] RESET_ROW1 = 25'd20490522;
  localparam logic [ROW_W-1:0] RESET_ROW2 = 25'd26984743;
  localparam logic [ROW_W-1:0] RESET_ROW3 = 25'd7100909;
  localparam logic [ROW_W-1:0] RESET_ROW4 = 25'd12776110;
  localparam logic [SYM_W-1:0] RESET_FILLER = 5'd6;

  // Pair queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // grid[r][c]: row r, column c; column 0 sits in the low bits of a row
  typedef logic [GRID_N-1:0][GRID_N-1:0][SYM_W-1:0] grid_t;

  // One pair job: two plaintext symbols and whether it ends its input item
  typedef struct packed {
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } loc_t;

  // Find a symbol in the grid; the last match in row-major order wins
  function automatic loc_t locate(input grid_t grid, input logic [SYM_W-1:0] sym);
    loc_t l;
    l = '0;
    for (int r = 0; r < GRID_N; r++) begin
      for (int c = 0; c < GRID_N; c++) begin
        if (grid[r][c] == sym) begin
          l.found = 1'b1;
          l.row   = IDX_W'(r);
          l.col   = IDX_W'(c);
        end
      end
    end
    return l;
  endfunction

  // Step one row or column with wrap
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] y;
    if (x == IDX_W'(GRID_N - 1)) y = '0;
    else y = x + 1'b1;
    return y;
  endfunction

endpackage

/* sv/rpb_if.sv */
// Valid/ready channel interfaces for input symbols and cipher results.
interface rpb_in_if;
  logic                     valid;
  logic                     ready;
  logic [rpb_pkg::SYM_W-1:0] symbol;
  logic                     end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface rpb_out_if;
  logic                     valid;
  logic                     ready;
  logic [rpb_pkg::SYM_W-1:0] cipher_symbol;
  logic                     last;

  modport source (output valid, output cipher_symbol, output last, input ready);
  modport sink   (input valid, input cipher_symbol, input last, output ready);
endinterface

/* sv/rpb_front.sv */
// Front end: drops spaces, pairs symbols, splits doubles and pads at end of text.
module rpb_front (
  input  logic                      clk,
  input  logic                      rst,
  rpb_in_if.sink                    in_ch,
  input  logic [rpb_pkg::SYM_W-1:0] filler,
  input  logic                      q_full,
  output logic                      push,
  output rpb_pkg::pair_t            push_data
);

  logic [rpb_pkg::SYM_W-1:0] held_symbol;
  logic                      held_valid;
  rpb_pkg::pair_t            spill;
  logic                      spill_valid;

  logic                      accept;
  logic [rpb_pkg::SYM_W-1:0] held_next;
  logic                      hv_next;
  rpb_pkg::pair_t            p1;
  rpb_pkg::pair_t            p2;
  logic                      p1_v;
  logic                      p2_v;

  // One extra pair may wait in the spill register; stall input until it leaves
  assign in_ch.ready = !spill_valid && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the item into zero, one or two pair jobs
  always_comb begin
    held_next = held_symbol;
    hv_next   = held_valid;
    p1_v      = 1'b0;
    p2_v      = 1'b0;
    p1        = '0;
    p2        = '0;
    if (in_ch.symbol != rpb_pkg::SPACE_SYMBOL) begin
      if (!held_valid) begin
        held_next = in_ch.symbol;
        hv_next   = 1'b1;
      end else if (held_symbol == in_ch.symbol) begin
        p1_v   = 1'b1;
        p1.a   = held_symbol;
        p1.b   = filler;
      end else begin
        p1_v      = 1'b1;
        p1.a      = held_symbol;
        p1.b      = in_ch.symbol;
        held_next = '0;
        hv_next   = 1'b0;
      end
    end
    if (in_ch.end_of_text && hv_next) begin
      p2_v      = 1'b1;
      p2.a      = held_next;
      p2.b      = filler;
      p2.last   = 1'b1;
      held_next = '0;
      hv_next   = 1'b0;
    end
    p1.last = !p2_v;
  end

  // Queue push: the spilled pair first, else the first pair of this item
  always_comb begin
    push      = 1'b0;
    push_data = p1;
    if (spill_valid) begin
      push      = !q_full;
      push_data = spill;
    end else if (accept && (p1_v || p2_v)) begin
      push      = 1'b1;
      push_data = p1_v ? p1 : p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_symbol <= '0;
      held_valid  <= 1'b0;
      spill_valid <= 1'b0;
    end else begin
      if (accept) begin
        held_symbol <= held_next;
        held_valid  <= hv_next;
      end
      if (spill_valid && !q_full) begin
        spill_valid <= 1'b0;
      end else if (accept && p1_v && p2_v) begin
        spill_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && p1_v && p2_v) begin
      spill <= p2;
    end
  end

  // End of text always leaves nothing pending
  a_eot_flush: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_text |=> !held_valid)
    else $error("symbol still pending after end of text");

  // A spilled pair only arises from a double at end of text
  a_spill_src: assert property (@(posedge clk) disable iff (rst)
    $rose(spill_valid) |-> $past(accept && in_ch.end_of_text && held_valid))
    else $error("spill without a flushed double");

endmodule

/* sv/rpb_queue.sv */
// Small FIFO of pair jobs between the front and back ends.
module rpb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpb_pkg::pair_t push_data,
  input  logic           pop,
  output rpb_pkg::pair_t head,
  output logic           empty,
  output logic           full
);

  rpb_pkg::pair_t                  mem [rpb_pkg::QUEUE_DEPTH];
  logic [rpb_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [rpb_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [rpb_pkg::QUEUE_CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == rpb_pkg::QUEUE_CW'(rpb_pkg::QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && empty))
    else $error("pair queue overflow or underflow");

endmodule

/* sv/rpb_back.sv */
// Back end: enciphers pair jobs against the key grid and sends two symbols each.
module rpb_back (
  input  logic                      clk,
  input  logic                      rst,
  input  rpb_pkg::grid_t            grid,
  input  rpb_pkg::pair_t            q_head,
  input  logic                      q_empty,
  output logic                      pop,
  rpb_out_if.source                 out_ch
);

  logic                      out_valid;
  logic [rpb_pkg::SYM_W-1:0] out_sym;
  logic                      out_last;
  logic                      sec_valid;
  logic [rpb_pkg::SYM_W-1:0] sec_sym;
  logic                      sec_last;

  logic                      load;
  rpb_pkg::loc_t             la;
  rpb_pkg::loc_t             lb;
  logic [rpb_pkg::SYM_W-1:0] oa;
  logic [rpb_pkg::SYM_W-1:0] ob;

  assign out_ch.valid         = out_valid;
  assign out_ch.cipher_symbol = out_sym;
  assign out_ch.last          = out_last;

  // Output register takes a new symbol when empty or being drained
  assign load = !out_valid || out_ch.ready;
  assign pop  = load && !sec_valid && !q_empty;

  // Pair rule on the queue head
  always_comb begin
    la = rpb_pkg::locate(grid, q_head.a);
    lb = rpb_pkg::locate(grid, q_head.b);
    oa = q_head.a;
    ob = q_head.b;
    if (la.found && lb.found) begin
      if (la.row == lb.row && la.col == lb.col) begin
        oa = grid[la.row][rpb_pkg::wrap_inc(la.col)];
        ob = grid[lb.row][rpb_pkg::wrap_inc(lb.col)];
      end else if (la.col == lb.col) begin
        oa = grid[rpb_pkg::wrap_inc(la.row)][la.col];
        ob = grid[rpb_pkg::wrap_inc(lb.row)][lb.col];
      end else if (la.row == lb.row) begin
        oa = grid[la.row][rpb_pkg::wrap_inc(la.col)];
        ob = grid[lb.row][rpb_pkg::wrap_inc(lb.col)];
      end else begin
        oa = grid[la.row][lb.col];
        ob = grid[lb.row][la.col];
      end
    end
  end

  // Control: output valid and second-symbol holding slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (load) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else begin
        out_valid <= !q_empty;
        sec_valid <= !q_empty;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid) begin
        out_sym  <= sec_sym;
        out_last <= sec_last;
      end else begin
        out_sym  <= oa;
        out_last <= 1'b0;
        sec_sym  <= ob;
        sec_last <= q_head.last;
      end
    end
  end

  // The second symbol of a pair never waits without the first in front of it
  a_sec_behind_first: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> out_valid)
    else $error("second symbol held with empty output register");

  // First symbol of a pair never carries last
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> !out_last)
    else $error("last flag on first symbol of a pair");

endmodule

/* sv/rune_playfair_bigram_encrypt.sv */
// Top level of the rune Playfair bigram encryptor: key registers, front, queue, back.
// Usage: symbols enter one item per cycle on in_ch while in_ch.ready is high;
// spaces (29) are dropped and the rest are paired, with doubles split and odd
// text padded by the filler symbol. Each pair becomes two cipher symbols on
// out_ch, one per cycle while out_ch.ready is high, with last set on the final
// symbol caused by an input item. An item is taken while the queue has room and
// no spilled pair waits; an end-of-text item that flushes a doubled pair queues
// two pairs. Otherwise the pace is set by the output port at one symbol per cycle.
// A pair is looked up in the grid at the head of a four-entry queue. Key rows
// and the filler are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while the block is idle, as the block itself does not enforce it.
module rune_playfair_bigram_encrypt (
  input  logic                          clk,
  input  logic                          rst,
  rpb_in_if.sink                        in_ch,
  rpb_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpb_pkg::ROW_W-1:0]     cfg_data
);

  rpb_pkg::grid_t            grid;
  logic [rpb_pkg::SYM_W-1:0] filler;

  logic           push;
  rpb_pkg::pair_t push_data;
  logic           pop;
  rpb_pkg::pair_t q_head;
  logic           q_empty;
  logic           q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid[0] <= rpb_pkg::RESET_ROW0;
      grid[1] <= rpb_pkg::RESET_ROW1;
      grid[2] <= rpb_pkg::RESET_ROW2;
      grid[3] <= rpb_pkg::RESET_ROW3;
      grid[4] <= rpb_pkg::RESET_ROW4;
      filler  <= rpb_pkg::RESET_FILLER;
    end else if (cfg_we) begin
      case (cfg_index)
        rpb_pkg::REG_KEY_ROW0: grid[0] <= cfg_data;
        rpb_pkg::REG_KEY_ROW1: grid[1] <= cfg_data;
        rpb_pkg::REG_KEY_ROW2: grid[2] <= cfg_data;
        rpb_pkg::REG_KEY_ROW3: grid[3] <= cfg_data;
        rpb_pkg::REG_KEY_ROW4: grid[4] <= cfg_data;
        rpb_pkg::REG_FILLER:   filler  <= cfg_data[rpb_pkg::SYM_W-1:0];
        default: ;
      endcase
    end
  end

  rpb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .filler    (filler),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rpb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rpb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .grid    (grid),
    .q_head  (q_head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* verif/tb_rune_playfair_bigram_encrypt.sv */
// Testbench for the rune Playfair bigram encryptor: directed pairs, register extremes, random text.
`timescale 1ns / 100ps

module tb_rune_playfair_bigram_encrypt;

  typedef logic [rpb_pkg::SYM_W-1:0] rune_t;
  typedef logic [rpb_pkg::ROW_W-1:0] row_t;

  typedef struct packed {
    rune_t sym;
    logic  last;
  } cipher_t;

  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_CAP     = 60;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rpb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rpb_pkg::ROW_W-1:0] cfg_data;

  rpb_in_if  in_ch ();
  rpb_out_if out_ch ();

  rune_playfair_bigram_encrypt i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: key grid, filler and the pending plaintext symbol
  row_t    key_rows [rpb_pkg::GRID_N];
  rune_t   fill_sym;
  rune_t   held_sym;
  bit      held_vld;
  cipher_t cipher_q [$];

  int mismatches;
  int cycle_count = 0;
  bit send_idle;
  bit sink_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Random gap length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic rune_t grid_cell(input int r, input int c);
    return key_rows[r % rpb_pkg::GRID_N][rpb_pkg::SYM_W * (c % rpb_pkg::GRID_N) +: rpb_pkg::SYM_W];
  endfunction

  // Position of a rune; a repeated value resolves to its last cell in row-major order
  function automatic bit find_rune(input rune_t s, output int row, output int col);
    bit hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < rpb_pkg::GRID_N; r++) begin
      for (int c = 0; c < rpb_pkg::GRID_N; c++) begin
        if (grid_cell(r, c) == s) begin
          hit = 1'b1;
          row = r;
          col = c;
        end
      end
    end
    return hit;
  endfunction

  function automatic void encipher_pair(input rune_t a, input rune_t b,
                                        output rune_t oa, output rune_t ob);
    int ra, ca, rb, cb;
    bit fa, fb;
    fa = find_rune(a, ra, ca);
    fb = find_rune(b, rb, cb);
    oa = a;
    ob = b;
    if (fa && fb) begin
      if (ca == cb && ra != rb) begin
        // same column: step down
        oa = grid_cell(ra + 1, ca);
        ob = grid_cell(rb + 1, cb);
      end else if (ra == rb) begin
        // same row or same cell: step right
        oa = grid_cell(ra, ca + 1);
        ob = grid_cell(rb, cb + 1);
      end else begin
        // rectangle: swap corners
        oa = grid_cell(ra, cb);
        ob = grid_cell(rb, ca);
      end
    end
  endfunction

  function automatic void push_cipher_pair(input rune_t a, input rune_t b);
    rune_t oa, ob;
    encipher_pair(a, b, oa, ob);
    cipher_q.insert(cipher_q.size(), cipher_t'{sym: oa, last: 1'b0});
    cipher_q.insert(cipher_q.size(), cipher_t'{sym: ob, last: 1'b0});
  endfunction

  // Expected cipher symbols for one accepted plaintext item
  function automatic void predict_cipher(input rune_t s, input logic eot);
    int n;
    n = 0;
    if (s != rpb_pkg::SPACE_SYMBOL) begin
      if (!held_vld) begin
        held_sym = s;
        held_vld = 1'b1;
      end else if (held_sym == s) begin
        // doubled: first goes with the filler, second stays pending
        push_cipher_pair(held_sym, fill_sym);
        n += 2;
      end else begin
        push_cipher_pair(held_sym, s);
        n += 2;
        held_vld = 1'b0;
        held_sym = '0;
      end
    end
    if (eot && held_vld) begin
      push_cipher_pair(held_sym, fill_sym);
      n += 2;
      held_vld = 1'b0;
      held_sym = '0;
    end
    if (n > 0) cipher_q[cipher_q.size() - 1].last = 1'b1;
  endfunction

  // Send one plaintext item; returns on the edge that accepts it
  task automatic send_text(input rune_t s, input logic eot);
    int gap;
    gap = 0;
    if (send_idle && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= s;
    in_ch.end_of_text <= eot;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    predict_cipher(s, eot);
  endtask

  // Stop sending and wait for every expected cipher symbol
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cipher_q.size() != 0);
  endtask

  // One register write; write enable stays high for back-to-back writes
  task automatic cfg_step(input logic [rpb_pkg::CFG_IDX_W-1:0] idx, input row_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == rpb_pkg::REG_FILLER) fill_sym = data[rpb_pkg::SYM_W-1:0];
    else key_rows[idx] = data;
  endtask

  // Write the whole key grid and the filler once the block has gone quiet
  task automatic load_key(input row_t rows [rpb_pkg::GRID_N], input rune_t fill);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_step(rpb_pkg::REG_KEY_ROW0, rows[0]);
    cfg_step(rpb_pkg::REG_KEY_ROW1, rows[1]);
    cfg_step(rpb_pkg::REG_KEY_ROW2, rows[2]);
    cfg_step(rpb_pkg::REG_KEY_ROW3, rows[3]);
    cfg_step(rpb_pkg::REG_KEY_ROW4, rows[4]);
    cfg_step(rpb_pkg::REG_FILLER, row_t'(fill));
    cfg_we <= 1'b0;
  endtask

  // Shuffled alphabet grid, or raw random rows full of repeats
  task automatic pick_grid(input bit raw, output row_t rows [rpb_pkg::GRID_N]);
    rune_t pool [30];
    rune_t tmp;
    int j;
    for (int i = 0; i < 30; i++) pool[i] = rune_t'(i);
    for (int i = 29; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int r = 0; r < rpb_pkg::GRID_N; r++) begin
      if (raw) begin
        rows[r] = row_t'($urandom);
      end else begin
        for (int c = 0; c < rpb_pkg::GRID_N; c++)
          rows[r][rpb_pkg::SYM_W * c +: rpb_pkg::SYM_W] = pool[rpb_pkg::GRID_N * r + c];
      end
    end
  endtask

  // Plaintext rune: mostly from the grid, with spaces and off-grid runes
  function automatic rune_t pick_plain();
    int r;
    rune_t s;
    r = $urandom_range(0, 99);
    if (r < 10) return rpb_pkg::SPACE_SYMBOL;
    if (r < 80) begin
      s = grid_cell($urandom_range(0, rpb_pkg::GRID_N - 1),
                    $urandom_range(0, rpb_pkg::GRID_N - 1));
      if (s > rpb_pkg::SPACE_SYMBOL) s = rune_t'($urandom_range(0, 28));
      return s;
    end
    return rune_t'($urandom_range(0, 29));
  endfunction

  // Reset grid: row, column and rectangle pairs, wraps, doubles, spaces and end-of-text flushes
  task automatic test_directed_pairs();
    send_text(grid_cell(0, 0), 1'b0);      // same row
    send_text(grid_cell(0, 3), 1'b0);
    send_text(grid_cell(1, 2), 1'b0);      // same column, wraps to top
    send_text(grid_cell(4, 2), 1'b0);
    send_text(grid_cell(0, 1), 1'b0);      // rectangle
    send_text(grid_cell(3, 4), 1'b0);
    send_text(grid_cell(0, 4), 1'b0);      // row wrap
    send_text(grid_cell(0, 2), 1'b0);
    send_text(grid_cell(2, 2), 1'b0);      // doubled pair split
    send_text(grid_cell(2, 2), 1'b0);
    send_text(grid_cell(2, 3), 1'b0);
    send_text(5'd30, 1'b0);                // off-grid runes pass through
    send_text(grid_cell(1, 1), 1'b0);
    send_text(5'd31, 1'b0);
    send_text(5'd0, 1'b0);
    send_text(rpb_pkg::SPACE_SYMBOL, 1'b0); // spaces between a pair
    send_text(grid_cell(3, 3), 1'b0);
    send_text(rpb_pkg::SPACE_SYMBOL, 1'b0);
    send_text(grid_cell(3, 1), 1'b0);
    send_text(rpb_pkg::SPACE_SYMBOL, 1'b1); // end of text, nothing pending
    send_text(grid_cell(3, 0), 1'b0);      // space with end of text flushes
    send_text(rpb_pkg::SPACE_SYMBOL, 1'b1);
    send_text(grid_cell(1, 3), 1'b0);      // double at end of text: four results
    send_text(grid_cell(1, 3), 1'b1);
    send_text(grid_cell(2, 0), 1'b1);      // lone rune with end of text
  endtask

  // All-zero and all-one grids, space as filler, a grid of repeats
  task automatic test_register_extremes();
    row_t rows [rpb_pkg::GRID_N];
    foreach (rows[r]) rows[r] = '0;
    load_key(rows, 5'd0);
    send_text(5'd0, 1'b0);
    send_text(5'd0, 1'b0);
    send_text(5'd5, 1'b0);
    send_text(5'd0, 1'b1);

    foreach (rows[r]) rows[r] = '1;
    load_key(rows, rpb_pkg::SPACE_SYMBOL);
    send_text(5'd31, 1'b0);
    send_text(5'd31, 1'b1);
    send_text(5'd3, 1'b1);

    foreach (rows[r])
      for (int c = 0; c < rpb_pkg::GRID_N; c++)
        rows[r][rpb_pkg::SYM_W * c +: rpb_pkg::SYM_W] = rune_t'($urandom_range(0, 3));
    load_key(rows, rune_t'($urandom_range(0, 3)));
    for (int i = 0; i < 16; i++) send_text(rune_t'($urandom_range(0, 4)), 1'b0);
    send_text(rpb_pkg::SPACE_SYMBOL, 1'b1);
  endtask

  // Random text over several keys; doubles, spaces and early ends mixed in
  task automatic test_random_text();
    row_t rows [rpb_pkg::GRID_N];
    rune_t s, prev;
    logic eot;
    for (int k = 0; k < 6; k++) begin
      pick_grid(k == 3, rows);
      load_key(rows, rune_t'($urandom_range(0, 29)));
      send_idle = (k != 1);
      sink_idle = (k != 1);
      prev = rpb_pkg::SPACE_SYMBOL;
      for (int i = 0; i < 50; i++) begin
        if (prev != rpb_pkg::SPACE_SYMBOL && $urandom_range(0, 99) < 15) s = prev;
        else s = pick_plain();
        eot = ($urandom_range(0, 99) < 8);
        send_text(s, eot);
        prev = s;
        // hold off until the block has emptied
        if (k == 2 && i == 30) drain_results();
      end
      send_text(rpb_pkg::SPACE_SYMBOL, 1'b1);
    end
    send_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Result side: ready with random stalls
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Compare each accepted cipher symbol with the oldest expectation
  initial begin : result_check
    cipher_t want;
    forever begin
      @(negedge clk);
      if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected cipher symbol %0d last %0b",
                                    out_ch.cipher_symbol, out_ch.last));
        end else begin
          want = cipher_q.pop_front();
          if (out_ch.cipher_symbol !== want.sym)
            report_mismatch($sformatf("cipher_symbol got %0d want %0d",
                                      out_ch.cipher_symbol, want.sym));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_ch.last, want.last));
        end
      end
    end
  end

  initial begin : main_seq
    mismatches  = 0;
    send_idle   = 1'b1;
    sink_idle   = 1'b1;
    key_rows[0] = rpb_pkg::RESET_ROW0;
    key_rows[1] = rpb_pkg::RESET_ROW1;
    key_rows[2] = rpb_pkg::RESET_ROW2;
    key_rows[3] = rpb_pkg::RESET_ROW3;
    key_rows[4] = rpb_pkg::RESET_ROW4;
    fill_sym    = rpb_pkg::RESET_FILLER;
    held_sym    = '0;
    held_vld    = 1'b0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= rpb_pkg::REG_KEY_ROW0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_pairs();
    test_register_extremes();
    test_random_text();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* rune_playfair_bigram_encrypt.f */
sv/rpb_pkg.sv
sv/rpb_if.sv
sv/rpb_front.sv
sv/rpb_queue.sv
sv/rpb_back.sv
sv/rune_playfair_bigram_encrypt.sv
verif/tb_rune_playfair_bigram_encrypt.sv
